/* sv/su2pq_pkg.sv */
// constants and pipeline types for the su2 quaternion projection core
package su2pq_pkg;

   localparam int IN_WIDTH      = 32;
   localparam int OUT_FRAC_BITS = 30;

   localparam int N_IN    = 8;
   localparam int N_LANE  = 4;
   localparam int SUM_W   = IN_WIDTH + 1;
   localparam int SQ_W    = 2 * SUM_W;
   localparam int NORM_W  = SQ_W + 2;
   localparam int QBITS   = OUT_FRAC_BITS + 1;
   localparam int OUT_W   = OUT_FRAC_BITS + 2;
   localparam int T_SHIFT = 2 * OUT_FRAC_BITS + 2;
   localparam int ACC_W   = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 8;

   localparam int REQ_W = ((N_IN * IN_WIDTH + 7) / 8) * 8;
   localparam int RSP_W = ((N_LANE * OUT_W + 7) / 8) * 8;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      acc_type           rm;
      acc_type           qa;
      logic [QBITS-1:0]  qv;
      logic              neg;
   } lane_type;

   typedef struct packed {
      logic                      valid;
      logic [NORM_W-1:0]         norm;
      lane_type [N_LANE-1:0]     lane;
   } stage_type;

endpackage

/* sv/su2_project_quaternion_core.sv */
// su2 projection of a 2x2 complex matrix onto a normalized quaternion
module su2_project_quaternion_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im
   input  logic [su2pq_pkg::REQ_W-1:0]    req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // q0, q1, q2, q3
   output logic [su2pq_pkg::RSP_W-1:0]    rsp_tdata,
   // zero_norm
   output logic [0:0]                     rsp_tuser
);
   // one request per cycle enters and one response per cycle leaves; the pipe is
   // a sum stage, a square stage, a norm stage, one restoring digit stage per
   // quotient bit, and the output register. the whole pipe advances together and
   // stalls only while a response waits in the output register. each quotient
   // bit comes from an exact compare of (2q-1)^2*norm against s^2*2^(2f+2), kept
   // incrementally so that every digit stage is a shifted add and a compare on a
   // wide word

   import su2pq_pkg::*;

   logic en;

   // stage a: doubled coefficients
   logic                           a_valid_ff;
   logic signed [SUM_W-1:0]        a_s_ff [N_LANE];
   logic signed [IN_WIDTH-1:0]     fld [N_IN];

   // stage b: sign, magnitude, square
   logic                           b_valid_ff;
   logic                           b_neg_ff [N_LANE];
   logic [SQ_W-1:0]                b_sq_ff [N_LANE];

   // digit stages
   stage_type                      st_ff [QBITS+1];
   stage_type                      st_in;

   // output register
   logic                           rsp_valid_ff;
   logic [RSP_W-1:0]               rsp_data_ff;
   logic                           rsp_zero_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   for (genvar i = 0; i < N_IN; i++) begin : g_fld
      assign fld[i] = signed'(req_tdata[i*IN_WIDTH +: IN_WIDTH]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
      if (en) begin
         // re(m00+m11), im(m01+m10), re(m01-m10), im(m00-m11)
         a_s_ff[0] <= SUM_W'(fld[0]) + SUM_W'(fld[6]);
         a_s_ff[1] <= SUM_W'(fld[3]) + SUM_W'(fld[5]);
         a_s_ff[2] <= SUM_W'(fld[2]) - SUM_W'(fld[4]);
         a_s_ff[3] <= SUM_W'(fld[1]) - SUM_W'(fld[7]);
      end
   end

   always_ff @(posedge clock) begin
      logic [SUM_W-1:0] mag;
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         for (int l = 0; l < N_LANE; l++) begin
            mag = a_s_ff[l][SUM_W-1] ? SUM_W'(-a_s_ff[l]) : SUM_W'(a_s_ff[l]);
            b_neg_ff[l] <= a_s_ff[l][SUM_W-1];
            b_sq_ff[l]  <= SQ_W'(mag) * SQ_W'(mag);
         end
      end
   end

   // norm and initial remainder: starting point q = 0, i.e. (2q-1)^2*n = n
   always_comb begin
      logic [NORM_W-1:0] nsum;
      acc_type           nacc;
      nsum = '0;
      for (int l = 0; l < N_LANE; l++) begin
         nsum = nsum + NORM_W'(b_sq_ff[l]);
      end
      nacc        = signed'(ACC_W'(nsum));
      st_in.valid = b_valid_ff;
      st_in.norm  = nsum;
      for (int l = 0; l < N_LANE; l++) begin
         st_in.lane[l].rm  = signed'(ACC_W'(b_sq_ff[l]) << T_SHIFT) - nacc;
         st_in.lane[l].qa  = -nacc;
         st_in.lane[l].qv  = '0;
         st_in.lane[l].neg = b_neg_ff[l];
      end
   end

   // one quotient bit: try q + 2^k
   function automatic stage_type step_stage(stage_type s, int k);
      stage_type r;
      acc_type   nacc;
      acc_type   inc;
      r    = s;
      nacc = signed'(ACC_W'(s.norm));
      for (int l = 0; l < N_LANE; l++) begin
         inc = (s.lane[l].qa <<< (k + 2)) + (nacc <<< (2 * k + 2));
         if (s.lane[l].rm >= inc) begin
            r.lane[l].rm    = s.lane[l].rm - inc;
            r.lane[l].qa    = s.lane[l].qa + (nacc <<< (k + 1));
            r.lane[l].qv[k] = 1'b1;
         end
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].valid <= 1'b0;
      end else if (en) begin
         st_ff[0] <= st_in;
      end
   end

   for (genvar j = 0; j < QBITS; j++) begin : g_digit
      stage_type nx_in;
      assign nx_in = step_stage(st_ff[j], QBITS - 1 - j);
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[j+1].valid <= 1'b0;
         end else if (en) begin
            st_ff[j+1] <= nx_in;
         end
      end
   end

   // sign restore, zero norm forces all four components to zero
   always_ff @(posedge clock) begin
      logic [OUT_W-1:0] qm;
      logic             zn;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= st_ff[QBITS].valid;
      end
      if (en) begin
         zn          = (st_ff[QBITS].norm == '0);
         rsp_zero_ff <= zn;
         for (int l = 0; l < N_LANE; l++) begin
            qm = zn ? '0 : OUT_W'(st_ff[QBITS].lane[l].qv);
            rsp_data_ff[l*OUT_W +: OUT_W] <= st_ff[QBITS].lane[l].neg ? -qm : qm;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_zero_ff;

   // a zero-norm response carries all zero components
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero norm response with nonzero data");

   // a waiting response blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while pipe stalled");

   // a request entering the pipe while it runs is not lost in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> a_valid_ff)
      else $error("accepted request dropped");

   // the q0 component magnitude never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> signed'(rsp_tdata[OUT_W-1:0]) <= (OUT_W'(1) <<< OUT_FRAC_BITS)
                  && signed'(rsp_tdata[OUT_W-1:0]) >= -(OUT_W'(1) <<< OUT_FRAC_BITS))
      else $error("q0 out of range");

endmodule
